// ----- hdl/pcsc_pkg.sv -----
package pcsc_pkg;

    // Store depths; both are powers of two, so the wrap of an index is a part-select
    localparam int DATA_WORDS = 1024;
    localparam int ATTR_BYTES = 4096;
    localparam int DATA_AW    = $clog2(DATA_WORDS);
    localparam int ATTR_AW    = $clog2(ATTR_BYTES);
    localparam int CLR_DEPTH  = (DATA_WORDS > ATTR_BYTES) ? DATA_WORDS : ATTR_BYTES;
    localparam int CLR_AW     = $clog2(CLR_DEPTH);

    localparam int CTRL_ENTRIES = 64;
    localparam int CTRL_AW      = $clog2(CTRL_ENTRIES);

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_EVENT   = 2'd2,
        OP_PRELOAD = 2'd3
    } t_opcode;

    localparam logic [7:0] REGION_CTRL = 8'h70;
    localparam logic [7:0] REGION_ATTR = 8'h10;

    localparam logic [7:0] OFS_STATUS = 8'h7c;
    localparam logic [7:0] OFS_ENABLE = 8'h74;
    localparam logic [7:0] OFS_ACTIVE = 8'h6c;
    localparam logic [7:0] OFS_CLEAR  = 8'h64;
    localparam logic [7:0] OFS_MODE   = 8'h58;

    localparam logic [CTRL_AW-1:0] ENT_MODE   = OFS_MODE[CTRL_AW+1:2];
    localparam logic [CTRL_AW-1:0] ENT_ENABLE = OFS_ENABLE[CTRL_AW+1:2];

    localparam logic [7:0] MODE_VPP_A = 8'h0b;
    localparam logic [7:0] MODE_VPP_B = 8'h1b;
    localparam logic [7:0] MODE_OFF   = 8'h00;
    localparam logic [7:0] MODE_PLAIN = 8'h0a;

    localparam logic [31:0] ST_INSERTED_VPP = 32'h0000_0018;
    localparam logic [31:0] ST_INSERTED     = 32'h0000_0002;

    localparam logic [31:0] ATTR_FILL = 32'hff00_ff00;
    localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;
    localparam logic [23:0] CIS_ADDR_A = 24'h004104;
    localparam logic [23:0] CIS_ADDR_B = 24'h004118;
    localparam logic [31:0] CIS_VAL_A  = 32'd5;
    localparam logic [31:0] CIS_VAL_B  = 32'd1;

    typedef struct packed {
        logic accept;
        logic load_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic removal;
        logic clear_last;
    } t_sts;

endpackage

// ----- hdl/pcsc_item_if.sv -----
interface pcsc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        card_present;
    logic        vpp_one_on;
    logic        vpp_two_on;

    modport source (
        output valid, opcode, address, write_data, card_present, vpp_one_on, vpp_two_on,
        input  ready
    );
    modport sink (
        input  valid, opcode, address, write_data, card_present, vpp_one_on, vpp_two_on,
        output ready
    );
endinterface

// ----- hdl/pcsc_result_if.sv -----
interface pcsc_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        slot_irq_raise;
    logic        slot_irq_lower;
    logic        lock_irq_raise;

    modport source (
        output valid, read_data, slot_irq_raise, slot_irq_lower, lock_irq_raise,
        input  ready
    );
    modport sink (
        input  valid, read_data, slot_irq_raise, slot_irq_lower, lock_irq_raise,
        output ready
    );
endinterface

// ----- hdl/pcsc_ctrl.sv -----
module pcsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  pcsc_pkg::t_sts  i_sts,
    output pcsc_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.load_out = 1'b0;
        o_cmd.clear    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                // hold the finished beat until the output slot frees up
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = i_sts.removal ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase

        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// ----- hdl/pcsc_dpath.sv -----
module pcsc_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pcsc_pkg::t_cmd  i_cmd,
    output pcsc_pkg::t_sts  o_sts,
    input  logic [1:0]      i_opcode,
    input  logic [31:0]     i_address,
    input  logic [31:0]     i_write_data,
    input  logic            i_card_present,
    input  logic            i_vpp_one_on,
    input  logic            i_vpp_two_on,
    output logic [31:0]     o_read_data,
    output logic            o_slot_irq_raise,
    output logic            o_slot_irq_lower,
    output logic            o_lock_irq_raise
);

    localparam int CTRL_AW = pcsc_pkg::CTRL_AW;
    localparam int DATA_AW = pcsc_pkg::DATA_AW;
    localparam int ATTR_AW = pcsc_pkg::ATTR_AW;
    localparam int CLR_AW  = pcsc_pkg::CLR_AW;

    // stores
    logic [7:0]  ctrl_mem [pcsc_pkg::CTRL_ENTRIES];
    logic [31:0] data_mem [pcsc_pkg::DATA_WORDS];
    logic [7:0]  attr_mem [pcsc_pkg::ATTR_BYTES];
    logic [pcsc_pkg::CTRL_ENTRIES-1:0] r_ctrl_valid;

    logic [7:0]  r_mode, r_enable;
    logic        r_inserted;
    logic [CLR_AW-1:0] r_clr_cnt;

    // latched item
    pcsc_pkg::t_opcode r_op;
    logic        r_is_ctrl, r_is_attr, r_present, r_vpp1, r_vpp2;
    logic [7:0]  r_ofs;
    logic [23:0] r_addr24;
    logic [31:0] r_wdata;

    // registered read data
    logic [7:0]  r_ctrl_rd;
    logic        r_ctrl_rd_vld;
    logic [31:0] r_data_rd;
    logic [7:0]  r_attr_lo, r_attr_hi;

    logic [31:0] r_out_data;
    logic        r_out_sraise, r_out_slower, r_out_lraise;

    pcsc_pkg::t_opcode in_op;
    logic        in_is_ctrl, in_is_attr;
    logic [CTRL_AW-1:0] in_ent;
    logic [DATA_AW-1:0] in_word;
    logic [ATTR_AW-1:0] in_attr_lo, in_attr_hi, in_attr_pre;

    logic [31:0] ctrl_value, status_value, attr_value, res_data;
    logic        res_sraise, res_slower, res_lraise;

    assign in_op       = pcsc_pkg::t_opcode'(i_opcode);
    assign in_is_ctrl  = (i_address[31:24] == pcsc_pkg::REGION_CTRL);
    assign in_is_attr  = (i_address[31:24] == pcsc_pkg::REGION_ATTR);
    assign in_ent      = i_address[10 +: CTRL_AW];
    assign in_word     = i_address[2 +: DATA_AW];
    assign in_attr_lo  = ATTR_AW'({1'b0, i_address[8:1]});
    assign in_attr_hi  = in_attr_lo + ATTR_AW'(1);
    assign in_attr_pre = i_address[ATTR_AW-1:0];

    assign o_sts.removal    = (r_op == pcsc_pkg::OP_EVENT) && !r_present;
    assign o_sts.clear_last = (r_clr_cnt == CLR_AW'(pcsc_pkg::CLR_DEPTH - 1));

    // control file: one write port, one read port; mode and enable shadowed in flops
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ctrl_rd <= ctrl_mem[in_ent];
            if (in_op == pcsc_pkg::OP_WRITE && in_is_ctrl) begin
                ctrl_mem[in_ent] <= i_write_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_valid <= '0;
            r_mode       <= '0;
            r_enable     <= '0;
        end else if (i_cmd.accept && in_op == pcsc_pkg::OP_WRITE && in_is_ctrl) begin
            r_ctrl_valid[in_ent] <= 1'b1;
            if (in_ent == pcsc_pkg::ENT_MODE) begin
                r_mode <= i_write_data[7:0];
            end
            if (in_ent == pcsc_pkg::ENT_ENABLE) begin
                r_enable <= i_write_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ctrl_rd_vld <= r_ctrl_valid[in_ent];
        end
    end

    // card data store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            if (r_clr_cnt <= CLR_AW'(pcsc_pkg::DATA_WORDS - 1)) begin
                data_mem[r_clr_cnt[DATA_AW-1:0]] <= '0;
            end
        end else if (i_cmd.accept) begin
            r_data_rd <= data_mem[in_word];
            if (in_op == pcsc_pkg::OP_WRITE && !in_is_ctrl && !in_is_attr) begin
                data_mem[in_word] <= i_write_data;
            end
        end
    end

    // attribute store: two read ports for the byte pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            if (r_clr_cnt <= CLR_AW'(pcsc_pkg::ATTR_BYTES - 1)) begin
                attr_mem[r_clr_cnt[ATTR_AW-1:0]] <= '0;
            end
        end else if (i_cmd.accept) begin
            r_attr_lo <= attr_mem[in_attr_lo];
            r_attr_hi <= attr_mem[in_attr_hi];
            if (in_op == pcsc_pkg::OP_PRELOAD) begin
                attr_mem[in_attr_pre] <= i_write_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_inserted <= 1'b0;
            r_op       <= pcsc_pkg::OP_READ;
            r_present  <= 1'b1;
        end else begin
            if (i_cmd.clear) begin
                r_clr_cnt <= o_sts.clear_last ? '0 : r_clr_cnt + CLR_AW'(1);
            end
            if (i_cmd.accept) begin
                r_op      <= in_op;
                r_present <= i_card_present;
                if (in_op == pcsc_pkg::OP_EVENT) begin
                    r_inserted <= i_card_present;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_ctrl <= in_is_ctrl;
            r_is_attr <= in_is_attr;
            r_ofs     <= i_address[15:8];
            r_addr24  <= i_address[23:0];
            r_wdata   <= i_write_data;
            r_vpp1    <= i_vpp_one_on;
            r_vpp2    <= i_vpp_two_on;
        end
    end

    // result decode
    always_comb begin
        if (r_mode == pcsc_pkg::MODE_VPP_A || r_mode == pcsc_pkg::MODE_VPP_B) begin
            status_value = r_inserted ? pcsc_pkg::ST_INSERTED_VPP
                         : {26'd0, ~r_vpp2, r_vpp1, ~r_vpp1, r_vpp2, 2'b00};
        end else if (r_mode == pcsc_pkg::MODE_OFF || r_mode == pcsc_pkg::MODE_PLAIN) begin
            status_value = r_inserted ? pcsc_pkg::ST_INSERTED : '0;
        end else begin
            status_value = '0;
        end

        if (r_ofs == pcsc_pkg::OFS_STATUS) begin
            ctrl_value = status_value;
        end else if (r_ofs == pcsc_pkg::OFS_ACTIVE) begin
            ctrl_value = r_inserted ? {24'd0, r_enable} : '0;
        end else begin
            ctrl_value = r_ctrl_rd_vld ? {24'd0, r_ctrl_rd} : '0;
        end

        if (!r_inserted) begin
            attr_value = pcsc_pkg::ALL_ONES;
        end else if (r_addr24[23:12] == '0) begin
            attr_value = pcsc_pkg::ATTR_FILL | {8'd0, r_attr_hi, 8'd0, r_attr_lo};
        end else if (r_addr24 == pcsc_pkg::CIS_ADDR_A) begin
            attr_value = pcsc_pkg::CIS_VAL_A;
        end else if (r_addr24 == pcsc_pkg::CIS_ADDR_B) begin
            attr_value = pcsc_pkg::CIS_VAL_B;
        end else begin
            attr_value = pcsc_pkg::ALL_ONES;
        end

        res_data   = '0;
        res_sraise = 1'b0;
        res_slower = 1'b0;
        res_lraise = 1'b0;
        case (r_op)
            pcsc_pkg::OP_READ: begin
                if (r_is_ctrl) begin
                    res_data = ctrl_value;
                end else if (r_is_attr) begin
                    res_data = attr_value;
                end else begin
                    res_data = r_inserted ? r_data_rd : pcsc_pkg::ALL_ONES;
                end
            end
            pcsc_pkg::OP_WRITE: begin
                if (r_is_attr) begin
                    res_data = pcsc_pkg::ALL_ONES;
                end else begin
                    res_data = r_wdata;
                end
                if (r_is_ctrl && r_inserted) begin
                    if (r_ofs == pcsc_pkg::OFS_ENABLE) begin
                        res_sraise = (r_wdata != '0);
                        res_slower = (r_wdata == '0);
                    end else if (r_ofs == pcsc_pkg::OFS_CLEAR) begin
                        res_slower = 1'b1;
                    end
                end
            end
            pcsc_pkg::OP_EVENT: begin
                res_sraise = 1'b1;
                res_lraise = !r_present;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data   <= res_data;
            r_out_sraise <= res_sraise;
            r_out_slower <= res_slower;
            r_out_lraise <= res_lraise;
        end
    end

    assign o_read_data      = r_out_data;
    assign o_slot_irq_raise = r_out_sraise;
    assign o_slot_irq_lower = r_out_slower;
    assign o_lock_irq_raise = r_out_lraise;

endmodule

// ----- hdl/pc_card_slot_controller_core.sv -----
// PC card slot controller core.
// i_item carries one bus read, bus write, card insert/remove event or attribute
// byte preload per beat; o_result returns exactly one beat per item, carrying
// the read data and the interrupt requests. Both are valid/ready channels.
// An item is taken in one cycle and the stores are read in that cycle into
// read registers; the decoded result is then loaded into the output
// register once that is free, and o_result shows it. The block works on one
// item at a time and takes no new item until the last result is loaded.
// The output register frees the input side: a new item is taken while the
// last result still waits, and only the decode of that new item waits for the
// receiver to take the old beat.
// After reset, and after every card removal event, the card data and
// attribute stores are swept to zero, one entry a cycle, over 4096 entries;
// no item is taken during the sweep. Control registers read zero after reset.
module pc_card_slot_controller_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pcsc_item_if.sink      i_item,
    pcsc_result_if.source  o_result
);

    pcsc_pkg::t_cmd cmd;
    pcsc_pkg::t_sts sts;

    pcsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pcsc_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_opcode         (i_item.opcode),
        .i_address        (i_item.address),
        .i_write_data     (i_item.write_data),
        .i_card_present   (i_item.card_present),
        .i_vpp_one_on     (i_item.vpp_one_on),
        .i_vpp_two_on     (i_item.vpp_two_on),
        .o_read_data      (o_result.read_data),
        .o_slot_irq_raise (o_result.slot_irq_raise),
        .o_slot_irq_lower (o_result.slot_irq_lower),
        .o_lock_irq_raise (o_result.lock_irq_raise)
    );

endmodule

// ----- verif/tb_pc_card_slot_controller_core.sv -----
module tb_pc_card_slot_controller_core;
    import pcsc_pkg::*;

    localparam int RANDOM_ITEMS = 1075;
    localparam int MAX_REMOVALS = 30;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        t_opcode     op;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic        present;
        logic        vpp1;
        logic        vpp2;
        logic        hold;
    } bus_item_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        sraise;
        logic        slower;
        logic        lraise;
    } slot_resp_t;

    logic i_clk;
    logic i_rst_n;

    pcsc_item_if   item_ch();
    pcsc_result_if result_ch();

    pc_card_slot_controller_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // Shadow of the slot state
    logic [7:0]  ctrl_regs [CTRL_ENTRIES];
    logic [31:0] data_mem  [DATA_WORDS];
    logic [7:0]  cis_mem   [ATTR_BYTES];
    logic        card_in;

    bus_item_t  bus_ops_q[$];
    slot_resp_t awaited_resp_q[$];

    bus_item_t drive_item;
    logic      item_beat;
    int        gap_left;
    int        stall_left;
    int        fail_count;
    int        results_seen;
    int        op_count [4];
    int        removal_count;

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] ctrl_addr(logic [7:0] ofs);
        return {REGION_CTRL, 8'h00, ofs, 8'h00};
    endfunction

    function automatic void queue_item(t_opcode op, logic [31:0] a, logic [31:0] d,
                                       logic pres, logic v1, logic v2, logic hold = 1'b0);
        bus_item_t it;
        it.op      = op;
        it.addr    = a;
        it.wdata   = d;
        it.present = pres;
        it.vpp1    = v1;
        it.vpp2    = v2;
        it.hold    = hold;
        bus_ops_q.push_back(it);
    endfunction

    // Quiet stretches in the middle, and none at all near the end
    function automatic bit idle_allowed();
        int left;
        left = bus_ops_q.size();
        return (left >= 150) && ((left / 100) % 4 != 1);
    endfunction

    function automatic slot_resp_t predict_slot_response(bus_item_t it);
        slot_resp_t  r;
        logic [7:0]  region;
        logic [7:0]  ofs;
        logic [7:0]  mode;
        logic [23:0] low24;
        logic [ATTR_AW-1:0] ci;
        r      = '0;
        region = it.addr[31:24];
        ofs    = it.addr[15:8];
        low24  = it.addr[23:0];
        case (it.op)
            OP_READ: begin
                if (region == REGION_CTRL) begin
                    if (ofs == OFS_STATUS) begin
                        mode = ctrl_regs[OFS_MODE[7:2]];
                        if (mode == MODE_VPP_A || mode == MODE_VPP_B)
                            r.rdata = card_in ? ST_INSERTED_VPP :
                                {26'd0, ~it.vpp2, it.vpp1, ~it.vpp1, it.vpp2, 2'b00};
                        else if (mode == MODE_OFF || mode == MODE_PLAIN)
                            r.rdata = card_in ? ST_INSERTED : 32'd0;
                        else
                            r.rdata = 32'd0;
                    end else if (ofs == OFS_ACTIVE) begin
                        r.rdata = card_in ? {24'd0, ctrl_regs[OFS_ENABLE[7:2]]} : 32'd0;
                    end else begin
                        r.rdata = {24'd0, ctrl_regs[ofs[7:2]]};
                    end
                end else if (region == REGION_ATTR) begin
                    if (!card_in) begin
                        r.rdata = ALL_ONES;
                    end else if (low24 < 24'd4096) begin
                        ci      = ATTR_AW'(low24[8:1]);
                        r.rdata = ATTR_FILL |
                                  {8'd0, cis_mem[ci + ATTR_AW'(1)], 8'd0, cis_mem[ci]};
                    end else if (low24 == CIS_ADDR_A) begin
                        r.rdata = CIS_VAL_A;
                    end else if (low24 == CIS_ADDR_B) begin
                        r.rdata = CIS_VAL_B;
                    end else begin
                        r.rdata = ALL_ONES;
                    end
                end else begin
                    r.rdata = card_in ? data_mem[it.addr[2 +: DATA_AW]] : ALL_ONES;
                end
            end
            OP_WRITE: begin
                if (region == REGION_CTRL) begin
                    ctrl_regs[ofs[7:2]] = it.wdata[7:0];
                    if (card_in) begin
                        if (ofs == OFS_ENABLE) begin
                            r.sraise = (it.wdata != 32'd0);
                            r.slower = (it.wdata == 32'd0);
                        end else if (ofs == OFS_CLEAR) begin
                            r.slower = 1'b1;
                        end
                    end
                    r.rdata = it.wdata;
                end else if (region == REGION_ATTR) begin
                    r.rdata = ALL_ONES;
                end else begin
                    data_mem[it.addr[2 +: DATA_AW]] = it.wdata;
                    r.rdata = it.wdata;
                end
            end
            OP_EVENT: begin
                card_in = it.present;
                if (!it.present) begin
                    r.lraise = 1'b1;
                    foreach (data_mem[k]) data_mem[k] = '0;
                    foreach (cis_mem[k]) cis_mem[k] = '0;
                end
                r.sraise = 1'b1;
            end
            default: begin
                cis_mem[it.addr[ATTR_AW-1:0]] = it.wdata[7:0];
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("mismatch at result %0d: %s got %h, expected %h",
                     results_seen, field, got, want);
    endtask

    // Sender: present the next beat once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!item_ch.valid || item_beat)) begin
            if (gap_left > 0) begin
                item_ch.valid <= 1'b0;
                gap_left--;
            end else if (bus_ops_q.size() != 0 &&
                         !(bus_ops_q[0].hold && awaited_resp_q.size() != 0)) begin
                drive_item = bus_ops_q.pop_front();
                item_ch.opcode       <= drive_item.op;
                item_ch.address      <= drive_item.addr;
                item_ch.write_data   <= drive_item.wdata;
                item_ch.card_present <= drive_item.present;
                item_ch.vpp_one_on   <= drive_item.vpp1;
                item_ch.vpp_two_on   <= drive_item.vpp2;
                item_ch.valid        <= 1'b1;
                if (idle_allowed() && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 14);
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            result_ch.ready <= 1'b1;
            if (idle_allowed() && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 14);
        end
    end

    // Monitor: check the result beat first, then predict the item beat
    always @(posedge i_clk) begin
        bus_item_t  seen;
        slot_resp_t got;
        slot_resp_t want;
        item_beat <= i_rst_n && item_ch.valid && item_ch.ready;
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                got.rdata  = result_ch.read_data;
                got.sraise = result_ch.slot_irq_raise;
                got.slower = result_ch.slot_irq_lower;
                got.lraise = result_ch.lock_irq_raise;
                if (awaited_resp_q.size() == 0) begin
                    report_mismatch("unexpected beat", got.rdata, 32'd0);
                end else begin
                    want = awaited_resp_q.pop_front();
                    if (got.rdata !== want.rdata)
                        report_mismatch("read_data", got.rdata, want.rdata);
                    if (got.sraise !== want.sraise)
                        report_mismatch("slot_irq_raise", 32'(got.sraise), 32'(want.sraise));
                    if (got.slower !== want.slower)
                        report_mismatch("slot_irq_lower", 32'(got.slower), 32'(want.slower));
                    if (got.lraise !== want.lraise)
                        report_mismatch("lock_irq_raise", 32'(got.lraise), 32'(want.lraise));
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                seen.op      = t_opcode'(item_ch.opcode);
                seen.addr    = item_ch.address;
                seen.wdata   = item_ch.write_data;
                seen.present = item_ch.card_present;
                seen.vpp1    = item_ch.vpp_one_on;
                seen.vpp2    = item_ch.vpp_two_on;
                seen.hold    = 1'b0;
                op_count[seen.op]++;
                if (seen.op == OP_EVENT && !seen.present)
                    removal_count++;
                awaited_resp_q.push_back(predict_slot_response(seen));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("timed out with %0d results still awaited", awaited_resp_q.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        int          kind;
        int          removals;
        logic [7:0]  ofs;
        logic [31:0] a;
        logic [31:0] d;
        logic        pres;
        logic        card;
        t_opcode     op;

        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.opcode       = '0;
        item_ch.address      = '0;
        item_ch.write_data   = '0;
        item_ch.card_present = 1'b0;
        item_ch.vpp_one_on   = 1'b0;
        item_ch.vpp_two_on   = 1'b0;
        result_ch.ready      = 1'b0;
        item_beat            = 1'b0;
        gap_left             = 0;
        stall_left           = 0;
        fail_count           = 0;
        results_seen         = 0;
        removal_count        = 0;
        card_in              = 1'b0;
        foreach (op_count[k]) op_count[k] = 0;
        foreach (ctrl_regs[k]) ctrl_regs[k] = '0;
        foreach (data_mem[k]) data_mem[k] = '0;
        foreach (cis_mem[k]) cis_mem[k] = '0;

        // Directed: status decode in each mode, interrupt requests, attribute
        // windows, data with and without a card, removal clearing the stores
        queue_item(OP_READ, ctrl_addr(OFS_STATUS), 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_WRITE, ctrl_addr(OFS_MODE), {24'hffffff, MODE_VPP_A}, 1'b1, 1'b0, 1'b0);
        queue_item(OP_READ, ctrl_addr(OFS_STATUS), 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_READ, ctrl_addr(OFS_STATUS), 32'd0, 1'b0, 1'b1, 1'b1);
        queue_item(OP_WRITE, ctrl_addr(OFS_ENABLE), 32'd1, 1'b0, 1'b0, 1'b0);
        queue_item(OP_EVENT, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
        queue_item(OP_WRITE, ctrl_addr(OFS_MODE), {24'hffffff, MODE_VPP_B}, 1'b0, 1'b0, 1'b0);
        queue_item(OP_READ, ctrl_addr(OFS_STATUS), 32'd0, 1'b0, 1'b1, 1'b0);
        queue_item(OP_WRITE, ctrl_addr(OFS_MODE), {24'd0, MODE_PLAIN}, 1'b0, 1'b0, 1'b1);
        queue_item(OP_READ, ctrl_addr(OFS_STATUS), 32'd0, 1'b1, 1'b0, 1'b1);
        // nonzero value with a zero low byte: raise, yet store zero
        queue_item(OP_WRITE, ctrl_addr(OFS_ENABLE), 32'h0000_0100, 1'b0, 1'b0, 1'b0);
        queue_item(OP_READ, ctrl_addr(OFS_ACTIVE), 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_WRITE, ctrl_addr(OFS_ENABLE), 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_WRITE, ctrl_addr(OFS_CLEAR), 32'hffff_ffff, 1'b1, 1'b1, 1'b1);
        queue_item(OP_PRELOAD, 32'hffff_f000, 32'hffff_ffa5, 1'b0, 1'b0, 1'b0);
        queue_item(OP_PRELOAD, 32'h0000_0100, 32'h0000_003c, 1'b0, 1'b0, 1'b0);
        queue_item(OP_PRELOAD, 32'h0000_00ff, 32'h1234_56c3, 1'b0, 1'b0, 1'b0);
        queue_item(OP_READ, {REGION_ATTR, 24'h0001fe}, 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_READ, {REGION_ATTR, CIS_ADDR_A}, 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_READ, {REGION_ATTR, 24'hffffff}, 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_WRITE, 32'hffff_fffc, 32'hffff_ffff, 1'b0, 1'b0, 1'b0);
        queue_item(OP_READ, 32'hffff_fffc, 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_EVENT, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_READ, 32'hffff_fffc, 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_READ, {REGION_ATTR, 24'h000000}, 32'd0, 1'b0, 1'b0, 1'b0);
        queue_item(OP_EVENT, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
        queue_item(OP_READ, 32'hffff_fffc, 32'd0, 1'b0, 1'b0, 1'b0);

        // Random: mostly register, data and attribute traffic with a card in,
        // rare removals, and a share of fully random beats
        removals = 0;
        card     = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            a    = $urandom;
            d    = $urandom;
            pres = 1'($urandom);
            kind = $urandom_range(0, 99);
            if (!card && $urandom_range(0, 3) != 0) begin
                op   = OP_EVENT;
                pres = 1'b1;
            end else if (kind < 25) begin
                case ($urandom_range(0, 9))
                    0, 5:    ofs = OFS_STATUS;
                    1:       ofs = OFS_ENABLE;
                    2:       ofs = OFS_ACTIVE;
                    3:       ofs = OFS_CLEAR;
                    4, 6:    ofs = OFS_MODE;
                    default: ofs = 8'($urandom);
                endcase
                a[31:24] = REGION_CTRL;
                a[15:8]  = ofs;
                op       = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
                if (ofs == OFS_MODE) begin
                    case ($urandom_range(0, 4))
                        0:       d[7:0] = MODE_VPP_A;
                        1:       d[7:0] = MODE_VPP_B;
                        2:       d[7:0] = MODE_OFF;
                        3:       d[7:0] = MODE_PLAIN;
                        default: ;
                    endcase
                end
                if (ofs == OFS_ENABLE || ofs == OFS_CLEAR) begin
                    case ($urandom_range(0, 3))
                        0:       d = 32'd0;
                        1:       d[7:0] = 8'h00;
                        default: ;
                    endcase
                end
            end else if (kind < 50) begin
                if (a[31:24] == REGION_CTRL || a[31:24] == REGION_ATTR)
                    a[31:24] = ~a[31:24];
                // keep to a few words so reads find what was written
                if ($urandom_range(0, 3) != 0)
                    a[11:2] = 10'($urandom_range(0, 15));
                op = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
            end else if (kind < 70) begin
                case ($urandom_range(0, 9))
                    7:       a[23:0] = CIS_ADDR_A;
                    8:       a[23:0] = CIS_ADDR_B;
                    9:       ;
                    default: a[23:0] = 24'($urandom_range(0, 515));
                endcase
                a[31:24] = REGION_ATTR;
                op       = ($urandom_range(0, 7) == 0) ? OP_WRITE : OP_READ;
            end else if (kind < 85) begin
                if ($urandom_range(0, 4) != 0)
                    a[11:0] = 12'($urandom_range(0, 257));
                op = OP_PRELOAD;
            end else if (kind < 90) begin
                op   = OP_EVENT;
                pres = ($urandom_range(0, 4) != 0);
            end else begin
                op = t_opcode'($urandom_range(0, 3));
            end
            if (op == OP_EVENT) begin
                // each removal costs a full store sweep
                if (!pres && removals >= MAX_REMOVALS)
                    pres = 1'b1;
                if (!pres)
                    removals++;
                card = pres;
            end
            queue_item(op, a, d, pres, 1'($urandom), 1'($urandom),
                       n == 0 || n == RANDOM_ITEMS / 2);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bus_ops_q.size() != 0 || item_ch.valid || awaited_resp_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("covered %0d reads, %0d writes, %0d preloads, %0d card events (%0d removals)",
                 op_count[OP_READ], op_count[OP_WRITE], op_count[OP_PRELOAD],
                 op_count[OP_EVENT], removal_count);
        $display("%0d result beats compared, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
